FILE: hw/rtl/ps2mct_pkg.sv
// Shared constants and types for the PS/2 mouse cursor tracker.
`default_nettype none
package ps2mct_pkg;

  localparam int COORD_BITS  = 12;
  localparam int SIZE_W      = 13;
  localparam int BYTE_W      = 8;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 3;
  localparam int OUT_FIELD_W = 2 * COORD_BITS + 2;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // Register indexes, taken from paddr[2]
  localparam logic REG_SCREEN_WIDTH  = 1'b0;
  localparam logic REG_SCREEN_HEIGHT = 1'b1;

  localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(1024);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(768);

  typedef struct packed {
    logic [SIZE_W-1:0] screen_height;
    logic [SIZE_W-1:0] screen_width;
  } cfg_t;

  typedef struct packed {
    logic                  right_pressed;
    logic                  left_pressed;
    logic [COORD_BITS-1:0] cursor_y;
    logic [COORD_BITS-1:0] cursor_x;
  } result_t;

endpackage
`default_nettype wire

FILE: hw/rtl/ps2mct_regs.sv
// APB configuration registers for screen width and height.
`default_nettype none
module ps2mct_regs (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_psel,
  input  wire logic                                cfg_penable,
  input  wire logic                                cfg_pwrite,
  input  wire logic [ps2mct_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  wire logic [ps2mct_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic      [ps2mct_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                                     cfg_pready,
  output ps2mct_pkg::cfg_t                         cfg
);

  logic [ps2mct_pkg::SIZE_W-1:0] width_r;
  logic [ps2mct_pkg::SIZE_W-1:0] height_r;
  logic                          wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= ps2mct_pkg::WIDTH_RESET;
      height_r <= ps2mct_pkg::HEIGHT_RESET;
    end else if (wr_en) begin
      if (cfg_paddr[2] == ps2mct_pkg::REG_SCREEN_WIDTH) begin
        width_r <= cfg_pwdata[ps2mct_pkg::SIZE_W-1:0];
      end else begin
        height_r <= cfg_pwdata[ps2mct_pkg::SIZE_W-1:0];
      end
    end
  end

  always_comb begin
    if (cfg_paddr[2] == ps2mct_pkg::REG_SCREEN_WIDTH) begin
      cfg_prdata = ps2mct_pkg::CFG_DATA_W'(width_r);
    end else begin
      cfg_prdata = ps2mct_pkg::CFG_DATA_W'(height_r);
    end
  end

  assign cfg.screen_width  = width_r;
  assign cfg.screen_height = height_r;

endmodule
`default_nettype wire

FILE: hw/rtl/ps2mct_track.sv
// Packet assembly, delta decode and cursor position update.
`default_nettype none
module ps2mct_track (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              step,
  input  wire logic [ps2mct_pkg::BYTE_W-1:0]     rx_byte,
  input  wire ps2mct_pkg::cfg_t                  cfg,
  output logic                                   last_byte,
  output ps2mct_pkg::result_t                    result
);

  localparam int CB    = ps2mct_pkg::COORD_BITS;
  localparam int SW    = ps2mct_pkg::SIZE_W;
  localparam int DW    = 11;
  localparam int SUM_W = ((CB > SW) ? CB : SW) + 2;

  localparam int HDR_LEFT    = 0;
  localparam int HDR_RIGHT   = 1;
  localparam int HDR_ALWAYS1 = 3;
  localparam int HDR_XSIGN   = 4;
  localparam int HDR_YSIGN   = 5;
  localparam int HDR_XOVF    = 6;
  localparam int HDR_YOVF    = 7;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_XDELTA = 3'b010,
    PH_YDELTA = 3'b100
  } phase_t;

  phase_t                           phase_r, phase_nxt;
  logic [ps2mct_pkg::BYTE_W-1:0]    header_r, header_nxt;
  logic [ps2mct_pkg::BYTE_W-1:0]    xbyte_r, xbyte_nxt;
  logic [CB-1:0]                    pos_x_r, pos_y_r;
  logic [CB-1:0]                    new_x, new_y;
  logic signed [DW-1:0]             dx, dy;

  // 9-bit signed delta, pushed a further 255 toward the sign on overflow
  function automatic logic signed [DW-1:0] make_delta(
    input logic [ps2mct_pkg::BYTE_W-1:0] b,
    input logic                          neg,
    input logic                          ovf
  );
    logic signed [DW-1:0] d;
    d = $signed({{(DW - 9){neg}}, neg, b});
    if (ovf) begin
      d = neg ? (d - DW'(255)) : (d + DW'(255));
    end
    return d;
  endfunction

  // Keep the old coordinate if the new one leaves the screen or the coordinate range
  function automatic logic [CB-1:0] move_axis(
    input logic [CB-1:0]         old,
    input logic signed [DW-1:0]  delta,
    input logic [SW-1:0]         size
  );
    logic signed [SUM_W-1:0] nv;
    logic signed [SUM_W-1:0] lim;
    logic signed [SUM_W-1:0] sz;
    nv  = $signed({{(SUM_W - CB){1'b0}}, old}) + $signed({{(SUM_W - DW){delta[DW-1]}}, delta});
    lim = $signed({{(SUM_W - CB){1'b0}}, {CB{1'b1}}});
    sz  = $signed({{(SUM_W - SW){1'b0}}, size});
    if (nv[SUM_W-1] || (nv >= sz) || (nv > lim)) begin
      return old;
    end
    return nv[CB-1:0];
  endfunction

  assign last_byte = (phase_r == PH_YDELTA);

  always_comb begin
    dx    = make_delta(xbyte_r, header_r[HDR_XSIGN], header_r[HDR_XOVF]);
    dy    = make_delta(rx_byte, header_r[HDR_YSIGN], header_r[HDR_YOVF]);
    new_x = move_axis(pos_x_r, dx, cfg.screen_width);
    new_y = move_axis(pos_y_r, -dy, cfg.screen_height);
  end

  always_comb begin
    phase_nxt  = phase_r;
    header_nxt = header_r;
    xbyte_nxt  = xbyte_r;
    case (phase_r)
      PH_XDELTA: begin
        xbyte_nxt = rx_byte;
        phase_nxt = PH_YDELTA;
      end
      PH_YDELTA: begin
        phase_nxt = PH_HEADER;
      end
      default: begin
        // drop a header without its always-one bit
        if (rx_byte[HDR_ALWAYS1]) begin
          header_nxt = rx_byte;
          phase_nxt  = PH_XDELTA;
        end else begin
          phase_nxt  = PH_HEADER;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HEADER;
      header_r <= '0;
      xbyte_r  <= '0;
      pos_x_r  <= '0;
      pos_y_r  <= '0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      header_r <= header_nxt;
      xbyte_r  <= xbyte_nxt;
      if (last_byte) begin
        pos_x_r <= new_x;
        pos_y_r <= new_y;
      end
    end
  end

  assign result.cursor_x      = new_x;
  assign result.cursor_y      = new_y;
  assign result.left_pressed  = header_r[HDR_LEFT];
  assign result.right_pressed = header_r[HDR_RIGHT];

endmodule
`default_nettype wire

FILE: hw/rtl/ps2_mouse_cursor_tracker_core.sv
// Top level of the PS/2 mouse cursor tracker: input register, tracker, result register.
//
//  channel | dir | handshake                  | payload
//  in_     | in  | in_tvalid / in_tready      | in_tdata[7:0] rx_byte
//  out_    | out | out_tvalid / out_tready    | out_tdata: cursor_x, cursor_y, buttons
//  cfg_    | in  | APB, pready always high    | screen_width @0, screen_height @4
//
// One byte per cycle unless a packet's third byte waits on a stalled result; a taken byte
// is registered in the input register before the tracker, then its result in the result register.
// rst_n is synchronous; it clears the packet phase, position and both valid flags.
// A stalled result holds the result register; the input register still takes header and
// X bytes, and waits only when it holds a third byte that has no free result slot.
`default_nettype none
module ps2_mouse_cursor_tracker_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  // rx_byte[7:0]
  input  wire logic [ps2mct_pkg::BYTE_W-1:0]        in_tdata,
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  // cursor_x[11:0], cursor_y[23:12], left_pressed[24], right_pressed[25], zero pad
  output logic [ps2mct_pkg::OUT_TDATA_W-1:0]        out_tdata,
  input  wire logic                                 cfg_psel,
  input  wire logic                                 cfg_penable,
  input  wire logic                                 cfg_pwrite,
  input  wire logic [ps2mct_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  wire logic [ps2mct_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic      [ps2mct_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                                      cfg_pready
);

  ps2mct_pkg::cfg_t              cfg;
  ps2mct_pkg::result_t           result;
  ps2mct_pkg::result_t           res_r;
  logic                          s1_valid_r;
  logic [ps2mct_pkg::BYTE_W-1:0] s1_byte_r;
  logic                          out_valid_r;
  logic                          last_byte;
  logic                          s1_adv;
  logic                          s1_step;
  logic                          produce;

  ps2mct_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  ps2mct_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (s1_step),
    .rx_byte   (s1_byte_r),
    .cfg       (cfg),
    .last_byte (last_byte),
    .result    (result)
  );

  // advance unless a packet result waits for a full, stalled result register
  assign s1_adv    = !last_byte || !out_valid_r || out_tready;
  assign s1_step   = s1_valid_r && s1_adv;
  assign produce   = s1_step && last_byte;
  assign in_tready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (produce) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (produce) begin
      res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = ps2mct_pkg::OUT_TDATA_W'(res_r);

endmodule
`default_nettype wire

FILE: hw/rtl/ps2mct_checker.sv
// Port-level checks for the PS/2 mouse cursor tracker, bound to the top level.
`default_nettype none
module ps2mct_checker (
  input wire logic                                 clk,
  input wire logic                                 rst_n,
  input wire logic                                 in_tvalid,
  input wire logic                                 in_tready,
  input wire logic                                 out_tvalid,
  input wire logic                                 out_tready,
  input wire logic [ps2mct_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // a fresh result follows an accepted input byte, through the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result without a matching input byte");

  // with an empty result register the input side never stalls
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with result register empty");

endmodule

bind ps2_mouse_cursor_tracker_core ps2mct_checker u_ps2mct_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
`default_nettype wire
